// File: rtl/assert_macros.svh
// assertion macros used by the rtl top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge outside reset
`define X87_ASSERT_ALWAYS(name, cond, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define X87_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/x87stf_pkg.sv
// shared types and constants for the x87 stack tag and fault unit
package x87stf_pkg;

  localparam int unsigned NumRegs = 8;
  localparam int unsigned IdxW    = 3;

  // command codes
  localparam logic [2:0] CMD_STORE   = 3'd0;
  localparam logic [2:0] CMD_EMPTY   = 3'd1;
  localparam logic [2:0] CMD_OVF     = 3'd2;
  localparam logic [2:0] CMD_UNF_REG = 3'd3;
  localparam logic [2:0] CMD_UNF_MEM = 3'd4;

  // tag codes
  localparam logic [1:0] TAG_VALID   = 2'd0;
  localparam logic [1:0] TAG_ZERO    = 2'd1;
  localparam logic [1:0] TAG_SPECIAL = 2'd2;
  localparam logic [1:0] TAG_EMPTY   = 2'd3;

  // memory kinds
  localparam logic [2:0] KIND_I16  = 3'd0;
  localparam logic [2:0] KIND_I32  = 3'd1;
  localparam logic [2:0] KIND_F32  = 3'd2;
  localparam logic [2:0] KIND_I64  = 3'd3;
  localparam logic [2:0] KIND_F64  = 3'd4;
  localparam logic [2:0] KIND_F80  = 3'd5;

  // status word bits
  localparam int unsigned SW_IE_BIT  = 0;
  localparam int unsigned SW_SF_BIT  = 6;
  localparam int unsigned SW_ES_BIT  = 7;
  localparam int unsigned SW_C1_BIT  = 9;
  localparam int unsigned SW_TOP_LSB = 11;

  localparam logic [15:0] CW_RESET    = 16'h0040;
  localparam logic [14:0] EXP_MAX     = 15'h7FFF;
  localparam logic [63:0] QNAN80_LOW  = 64'hC000_0000_0000_0000;
  localparam logic [15:0] QNAN80_HIGH = 16'hFFFF;

  typedef struct packed {
    logic [2:0]  command;
    logic [2:0]  st_source;
    logic [2:0]  st_dest;
    logic        pop_after;
    logic [31:0] mem_addr;
    logic [2:0]  mem_kind;
    logic [63:0] value_fraction;
    logic [15:0] value_sign_exp;
  } in_item_t;

  typedef struct packed {
    logic        fault;
    logic [1:0]  tag_value;
    logic [2:0]  stack_top;
    logic [15:0] status_word;
    logic        mem_write_valid;
    logic [31:0] mem_write_addr;
    logic [2:0]  mem_write_kind;
    logic [63:0] mem_write_low;
    logic [15:0] mem_write_high;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic load;  // capture the accepted item
    logic exec;  // update state and load the result register
  } dp_cmd_t;

endpackage

// File: rtl/x87stf_in_if.sv
// input item channel
interface x87stf_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  command;
  logic [2:0]  st_source;
  logic [2:0]  st_dest;
  logic        pop_after;
  logic [31:0] mem_addr;
  logic [2:0]  mem_kind;
  logic [63:0] value_fraction;
  logic [15:0] value_sign_exp;

  modport source (
    output valid, command, st_source, st_dest, pop_after, mem_addr, mem_kind,
           value_fraction, value_sign_exp,
    input  ready
  );
  modport sink (
    input  valid, command, st_source, st_dest, pop_after, mem_addr, mem_kind,
           value_fraction, value_sign_exp,
    output ready
  );
endinterface

// File: rtl/x87stf_out_if.sv
// result item channel
interface x87stf_out_if;
  logic        valid;
  logic        ready;
  logic        fault;
  logic [1:0]  tag_value;
  logic [2:0]  stack_top;
  logic [15:0] status_word;
  logic        mem_write_valid;
  logic [31:0] mem_write_addr;
  logic [2:0]  mem_write_kind;
  logic [63:0] mem_write_low;
  logic [15:0] mem_write_high;

  modport source (
    output valid, fault, tag_value, stack_top, status_word, mem_write_valid,
           mem_write_addr, mem_write_kind, mem_write_low, mem_write_high,
    input  ready
  );
  modport sink (
    input  valid, fault, tag_value, stack_top, status_word, mem_write_valid,
           mem_write_addr, mem_write_kind, mem_write_low, mem_write_high,
    output ready
  );
endinterface

// File: rtl/x87_stack_tag_fault_unit.sv
// top level of the x87 register stack tag and stack fault unit
// the result register loads when the captured item executes, once the register is free
// each item is captured, then executed; a new item is accepted only after the execute step
// a waiting result does not block accepting the next item; execute waits for it
// reset (rst, synchronous): all tags zero, top 0, status 0, control word 0x0040
module x87_stack_tag_fault_unit
  import x87stf_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [15:0]  cfg_data,
  x87stf_in_if.sink    item_in,
  x87stf_out_if.source result_out
);

`include "assert_macros.svh"

  dp_cmd_t   cmd;
  in_item_t  in_item;
  out_item_t out_item;

  // pack the incoming item fields
  assign in_item = '{
    command:        item_in.command,
    st_source:      item_in.st_source,
    st_dest:        item_in.st_dest,
    pop_after:      item_in.pop_after,
    mem_addr:       item_in.mem_addr,
    mem_kind:       item_in.mem_kind,
    value_fraction: item_in.value_fraction,
    value_sign_exp: item_in.value_sign_exp
  };

  // sequencing: accept in idle, execute once the result register is free
  x87stf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (item_in.valid),
    .in_ready  (item_in.ready),
    .out_valid (result_out.valid),
    .out_ready (result_out.ready),
    .cmd       (cmd)
  );

  // tag word, top pointer, status and the registered result
  x87stf_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .in_item  (in_item),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .out_item (out_item)
  );

  // unpack the result register onto the channel
  assign result_out.fault           = out_item.fault;
  assign result_out.tag_value       = out_item.tag_value;
  assign result_out.stack_top       = out_item.stack_top;
  assign result_out.status_word     = out_item.status_word;
  assign result_out.mem_write_valid = out_item.mem_write_valid;
  assign result_out.mem_write_addr  = out_item.mem_write_addr;
  assign result_out.mem_write_kind  = out_item.mem_write_kind;
  assign result_out.mem_write_low   = out_item.mem_write_low;
  assign result_out.mem_write_high  = out_item.mem_write_high;

  // one item in flight: accepting blocks the input for the next cycle
  `X87_ASSERT_NEXT(a_busy_after_accept, item_in.valid && item_in.ready,
                   !item_in.ready, "input ready right after accept")
  // a reported fault always leaves the stack fault flag set
  `X87_ASSERT_ALWAYS(a_fault_sets_sf,
                     !result_out.valid || !result_out.fault ||
                     result_out.status_word[SW_SF_BIT], "fault without stack fault flag")
  // memory writes only come from a fault response
  `X87_ASSERT_ALWAYS(a_write_needs_fault,
                     !result_out.valid || !result_out.mem_write_valid || result_out.fault,
                     "memory write without fault")
  // status word top field mirrors the top pointer
  `X87_ASSERT_ALWAYS(a_top_in_status,
                     !result_out.valid ||
                     (result_out.status_word[SW_TOP_LSB +: IdxW] == result_out.stack_top),
                     "status top mismatch")

endmodule

// File: rtl/x87stf_ctrl.sv
// controller state machine: accept, execute, result register occupancy
module x87stf_ctrl
  import x87stf_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  output dp_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state, state_next;
  logic   out_full, out_full_next;
  logic   do_exec;

  assign in_ready  = (state == S_IDLE);
  assign out_valid = out_full;
  assign do_exec   = (state == S_EXEC) && (!out_full || out_ready);
  assign cmd.load  = in_valid && in_ready;
  assign cmd.exec  = do_exec;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_valid) state_next = S_EXEC;
      S_EXEC: if (do_exec) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    out_full_next = out_full;
    if (do_exec) begin
      out_full_next = 1'b1;
    end else if (out_ready) begin
      out_full_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      out_full <= 1'b0;
    end else begin
      state    <= state_next;
      out_full <= out_full_next;
    end
  end

endmodule

// File: rtl/x87stf_dp.sv
// datapath: tag word, top pointer, status and control words, result register
module x87stf_dp
  import x87stf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  dp_cmd_t     cmd,
  input  in_item_t    in_item,
  input  logic        cfg_we,
  input  logic [15:0] cfg_data,
  output out_item_t   out_item
);

  in_item_t       item;
  logic [1:0]     tags [NumRegs];
  logic [1:0]     tags_next [NumRegs];
  logic [IdxW-1:0] top, top_next;
  logic [15:0]    sw, sw_next;
  logic [15:0]    cw;
  out_item_t      res, res_next;

  logic            masked;
  logic [IdxW-1:0] src_phys, dst_phys, below, addressed;
  logic [14:0]     exponent;
  logic [1:0]      class_tag;

  function automatic logic [63:0] qnan_low(input logic [2:0] kind);
    logic [63:0] v;
    v = '0;
    unique case (kind)
      KIND_I16: v = 64'h0000_0000_0000_8000;
      KIND_I32: v = 64'h0000_0000_8000_0000;
      KIND_F32: v = 64'h0000_0000_FFC0_0000;
      KIND_I64: v = 64'h8000_0000_0000_0000;
      KIND_F64: v = 64'hFFF8_0000_0000_0000;
      KIND_F80: v = QNAN80_LOW;
      default:  v = '0;
    endcase
    return v;
  endfunction

  function automatic logic [15:0] fault_status(input logic [15:0] s, input logic m,
                                               input logic ovf);
    logic [15:0] r;
    r = s;
    if (!m) r[SW_ES_BIT] = 1'b1;
    r[SW_IE_BIT] = 1'b1;
    r[SW_SF_BIT] = 1'b1;
    r[SW_C1_BIT] = ovf;
    return r;
  endfunction

  assign masked   = cw[SW_IE_BIT];
  assign src_phys = item.st_source + top;
  assign dst_phys = item.st_dest + top;
  assign below    = top - IdxW'(1);
  assign exponent = item.value_sign_exp[14:0];

  // classify the stored value
  always_comb begin
    if (exponent == '0 && item.value_fraction == '0) begin
      class_tag = TAG_ZERO;
    end else if (exponent == '0 || exponent == EXP_MAX || !item.value_fraction[63]) begin
      class_tag = TAG_SPECIAL;
    end else begin
      class_tag = TAG_VALID;
    end
  end

  always_comb begin
    tags_next = tags;
    top_next  = top;
    sw_next   = sw;
    addressed = src_phys;
    res_next  = '0;
    unique case (item.command)
      CMD_STORE: tags_next[src_phys] = class_tag;
      CMD_EMPTY: tags_next[src_phys] = TAG_EMPTY;
      CMD_OVF: begin
        addressed = below;
        if (tags[below] != TAG_EMPTY) begin
          res_next.fault = 1'b1;
          if (masked) begin
            top_next         = below;
            tags_next[below] = TAG_SPECIAL;
          end
          sw_next = fault_status(sw, masked, 1'b1);
        end
      end
      CMD_UNF_REG, CMD_UNF_MEM: begin
        if (tags[src_phys] == TAG_EMPTY) begin
          res_next.fault = 1'b1;
          if (masked) begin
            if (item.command == CMD_UNF_REG) begin
              tags_next[dst_phys] = TAG_SPECIAL;
            end else if (item.mem_kind <= KIND_F80) begin
              res_next.mem_write_valid = 1'b1;
              res_next.mem_write_addr  = item.mem_addr;
              res_next.mem_write_kind  = item.mem_kind;
              res_next.mem_write_low   = qnan_low(item.mem_kind);
              res_next.mem_write_high  = (item.mem_kind == KIND_F80) ? QNAN80_HIGH : '0;
            end
            // pop after the qnan load
            if (item.pop_after) begin
              tags_next[top] = TAG_EMPTY;
              top_next       = top + IdxW'(1);
            end
          end
          sw_next = fault_status(sw, masked, 1'b0);
        end
      end
      default: ;
    endcase
    res_next.tag_value   = tags_next[addressed];
    res_next.stack_top   = top_next;
    res_next.status_word = sw_next;
    res_next.status_word[SW_TOP_LSB +: IdxW] = top_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NumRegs; i++) tags[i] <= TAG_ZERO;
      top <= '0;
      sw  <= '0;
      cw  <= CW_RESET;
    end else begin
      if (cmd.exec) begin
        tags <= tags_next;
        top  <= top_next;
        sw   <= sw_next;
      end
      if (cfg_we) cw <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) item <= in_item;
    if (cmd.exec) res  <= res_next;
  end

  assign out_item = res;

endmodule

// File: tb/testbench.sv
// self-checking testbench for the x87 register stack tag and stack fault unit
module testbench;
  import x87stf_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // cycles with no item moving on either channel before the run is abandoned
  localparam int unsigned WATCHDOG_LIMIT = 1000;
  // settle time after the last result
  localparam int unsigned DRAIN_PAD = 4;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we;
  logic [15:0] cfg_data;

  x87stf_in_if  in_ch ();
  x87stf_out_if out_ch ();

  x87_stack_tag_fault_unit u_top (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .item_in    (in_ch),
    .result_out (out_ch)
  );

  // 10 ns clock, first rising edge at 5 ns
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // predictor state: physical registers, tags, top pointer, status, control
  // ---------------------------------------------------------------------------
  logic [63:0] st_frac [8];
  logic [15:0] st_sexp [8];
  logic [1:0]  st_tags [8];
  logic [2:0]  top_ptr;
  logic [15:0] status_bits;
  logic [15:0] ctrl_word;

  // results worked out at input acceptance, oldest first
  out_item_t   predicted_results [$];

  int unsigned send_idle_pct = 0;  // chance per cycle that the sender holds off
  int unsigned stall_pct     = 0;  // chance per cycle that the receiver stalls
  int unsigned error_count   = 0;
  int unsigned quiet_cycles  = 0;

  // the register receives the indefinite qnan and is tagged special
  function automatic void load_indefinite(input logic [2:0] idx);
    st_frac[idx] = QNAN80_LOW;
    st_sexp[idx] = QNAN80_HIGH;
    st_tags[idx] = TAG_SPECIAL;
  endfunction

  // stack fault flags: ie, sf always; es only when invalid is unmasked;
  // c1 tells overflow (1) from underflow (0)
  function automatic void note_stack_fault(input logic overflow);
    if (!ctrl_word[SW_IE_BIT]) status_bits[SW_ES_BIT] = 1'b1;
    status_bits[SW_IE_BIT] = 1'b1;
    status_bits[SW_SF_BIT] = 1'b1;
    status_bits[SW_C1_BIT] = overflow;
  endfunction

  // applies one command to the predictor state and returns the result item
  function automatic out_item_t predict_stack_step(input in_item_t it);
    out_item_t   res;
    logic [2:0]  at;
    logic        masked;
    logic [14:0] ex;
    res    = '0;
    at     = it.st_source + top_ptr;  // st(n) to physical, wraps mod 8
    masked = ctrl_word[SW_IE_BIT];
    ex     = it.value_sign_exp[14:0];
    case (it.command)
      CMD_STORE: begin
        st_frac[at] = it.value_fraction;
        st_sexp[at] = it.value_sign_exp;
        if (ex == '0 && it.value_fraction == '0) st_tags[at] = TAG_ZERO;
        // denormal, infinity, nan and unnormal all tag special
        else if (ex == '0 || ex == EXP_MAX || !it.value_fraction[63])
          st_tags[at] = TAG_SPECIAL;
        else st_tags[at] = TAG_VALID;
      end
      CMD_EMPTY: st_tags[at] = TAG_EMPTY;
      CMD_OVF: begin
        // a push would land on st(-1); it has to be empty
        at = top_ptr - 3'd1;
        if (st_tags[at] != TAG_EMPTY) begin
          res.fault = 1'b1;
          if (masked) begin
            top_ptr = at;
            load_indefinite(at);
          end
          note_stack_fault(1'b1);
        end
      end
      CMD_UNF_REG, CMD_UNF_MEM: begin
        if (st_tags[at] == TAG_EMPTY) begin
          res.fault = 1'b1;
          if (masked) begin
            if (it.command == CMD_UNF_REG) begin
              load_indefinite(it.st_dest + top_ptr);
            end else if (it.mem_kind <= KIND_F80) begin
              // undefined kinds still fault, and pop if asked, but write nothing
              res.mem_write_valid = 1'b1;
              res.mem_write_addr  = it.mem_addr;
              res.mem_write_kind  = it.mem_kind;
              case (it.mem_kind)
                KIND_I16: res.mem_write_low = 64'h0000_0000_0000_8000;
                KIND_I32: res.mem_write_low = 64'h0000_0000_8000_0000;
                KIND_F32: res.mem_write_low = 64'h0000_0000_FFC0_0000;
                KIND_I64: res.mem_write_low = 64'h8000_0000_0000_0000;
                KIND_F64: res.mem_write_low = 64'hFFF8_0000_0000_0000;
                default:  res.mem_write_low = QNAN80_LOW;
              endcase
              if (it.mem_kind == KIND_F80) res.mem_write_high = QNAN80_HIGH;
            end
            if (it.pop_after) begin
              st_tags[top_ptr] = TAG_EMPTY;
              top_ptr = top_ptr + 3'd1;
            end
          end
          note_stack_fault(1'b0);
        end
      end
      default: ;  // undefined command codes leave everything alone
    endcase
    res.tag_value   = st_tags[at];
    res.stack_top   = top_ptr;
    res.status_word = status_bits;
    res.status_word[SW_TOP_LSB +: 3] = top_ptr;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // result side: random stalls, and every accepted result against the oldest
  // prediction
  // ---------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [63:0] want_v,
                             input logic [63:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, want_v, got_v);
      error_count++;
    end
  endtask

  always @(posedge clk) begin : result_monitor
    out_item_t want;
    out_ch.ready <= ($urandom_range(99) >= stall_pct);
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (predicted_results.size() == 0) begin
        $display("%0t: result with nothing pending, expected none actual fault %0h tag %0h",
                 $time, out_ch.fault, out_ch.tag_value);
        error_count++;
      end else begin
        want = predicted_results.pop_front();
        check_field("fault", 64'(want.fault), 64'(out_ch.fault));
        check_field("tag_value", 64'(want.tag_value), 64'(out_ch.tag_value));
        check_field("stack_top", 64'(want.stack_top), 64'(out_ch.stack_top));
        check_field("status_word", 64'(want.status_word), 64'(out_ch.status_word));
        check_field("mem_write_valid", 64'(want.mem_write_valid),
                    64'(out_ch.mem_write_valid));
        check_field("mem_write_addr", 64'(want.mem_write_addr), 64'(out_ch.mem_write_addr));
        check_field("mem_write_kind", 64'(want.mem_write_kind), 64'(out_ch.mem_write_kind));
        check_field("mem_write_low", want.mem_write_low, out_ch.mem_write_low);
        check_field("mem_write_high", 64'(want.mem_write_high), 64'(out_ch.mem_write_high));
      end
    end
  end

  // watchdog: too long with no item moving on either side ends the run
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // input side
  // ---------------------------------------------------------------------------
  function automatic in_item_t make_item(input logic [2:0] cmd, input logic [2:0] src,
                                         input logic [2:0] dst, input logic pop,
                                         input logic [31:0] addr, input logic [2:0] kind,
                                         input logic [63:0] frac, input logic [15:0] sexp);
    in_item_t it;
    it.command        = cmd;
    it.st_source      = src;
    it.st_dest        = dst;
    it.pop_after      = pop;
    it.mem_addr       = addr;
    it.mem_kind       = kind;
    it.value_fraction = frac;
    it.value_sign_exp = sexp;
    return it;
  endfunction

  // called in the time step of a rising edge; returns in the step of the edge
  // that accepted the item, with valid still high so back-to-back items flow
  task automatic send_item(input in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.command        <= it.command;
    in_ch.st_source      <= it.st_source;
    in_ch.st_dest        <= it.st_dest;
    in_ch.pop_after      <= it.pop_after;
    in_ch.mem_addr       <= it.mem_addr;
    in_ch.mem_kind       <= it.mem_kind;
    in_ch.value_fraction <= it.value_fraction;
    in_ch.value_sign_exp <= it.value_sign_exp;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predicted_results.push_back(predict_stack_step(it));
  endtask

  // stop sending and wait until every predicted result has come back
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (predicted_results.size() != 0) @(posedge clk);
    repeat (DRAIN_PAD) @(posedge clk);
  endtask

  // control word writes only happen with the unit idle
  task automatic set_control_word(input logic [15:0] word);
    drain_results();
    cfg_we   <= 1'b1;
    cfg_data <= word;
    @(posedge clk);
    cfg_we    <= 1'b0;
    ctrl_word  = word;
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // every classification of a stored value, plus all-ones on the unused fields
  task automatic test_store_classification();
    send_item(make_item(CMD_STORE, 3'd0, 3'd0, 1'b0, '0, KIND_I16, 64'h0, 16'h0000));
    // denormal
    send_item(make_item(CMD_STORE, 3'd1, 3'd0, 1'b0, '0, KIND_I16, 64'h1, 16'h0000));
    // infinity
    send_item(make_item(CMD_STORE, 3'd2, 3'd0, 1'b0, '0, KIND_I16,
                        64'h8000_0000_0000_0000, 16'h7FFF));
    // nan with every bit set, other fields at their maximum too
    send_item(make_item(CMD_STORE, 3'd3, 3'd7, 1'b1, 32'hFFFF_FFFF, 3'd7,
                        64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF));
    // unnormal: integer bit clear with a normal exponent
    send_item(make_item(CMD_STORE, 3'd4, 3'd0, 1'b0, '0, KIND_I16,
                        64'h7FFF_FFFF_FFFF_FFFF, 16'h3FFF));
    // pseudo-denormal: exponent zero, integer bit set
    send_item(make_item(CMD_STORE, 3'd5, 3'd0, 1'b0, '0, KIND_I16,
                        64'h8000_0000_0000_0000, 16'h0000));
    // largest finite negative value
    send_item(make_item(CMD_STORE, 3'd6, 3'd0, 1'b0, '0, KIND_I16,
                        64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFE));
  endtask

  // faults with invalid unmasked: flags and es only, no register, memory or pop
  task automatic test_unmasked_faults();
    // reset control word leaves invalid unmasked; st(-1) is tagged zero
    send_item(make_item(CMD_OVF, 3'd0, 3'd0, 1'b0, '0, KIND_I16, '0, '0));
    set_control_word(16'h0000);
    send_item(make_item(CMD_EMPTY, 3'd7, 3'd0, 1'b0, '0, KIND_I16, '0, '0));
    send_item(make_item(CMD_UNF_REG, 3'd7, 3'd0, 1'b1, '0, KIND_I16, '0, '0));
    send_item(make_item(CMD_UNF_MEM, 3'd7, 3'd0, 1'b1, 32'h1234_5678, KIND_F80, '0, '0));
    // st(-1) now empty, so no overflow
    send_item(make_item(CMD_OVF, 3'd0, 3'd0, 1'b0, '0, KIND_I16, '0, '0));
  endtask

  // masked responses: qnan per memory kind, qnan into a register, pops, push
  task automatic test_masked_faults();
    set_control_word(16'hFFFF);
    for (int k = KIND_I16; k <= KIND_F80; k++) begin
      send_item(make_item(CMD_UNF_MEM, 3'd7, 3'd0, 1'b0, $urandom, k[2:0], '0, '0));
    end
    // memory qnan followed by a pop
    send_item(make_item(CMD_UNF_MEM, 3'd7, 3'd0, 1'b1, 32'hFFFF_FFFF, KIND_F80, '0, '0));
    // st(0) holds a value, no underflow
    send_item(make_item(CMD_UNF_REG, 3'd0, 3'd0, 1'b0, '0, KIND_I16, '0, '0));
    // qnan lands on the empty source itself, then the pop empties the old top
    send_item(make_item(CMD_UNF_REG, 3'd7, 3'd7, 1'b1, '0, KIND_I16, '0, '0));
    // refill st(-1), then a masked overflow pushes the qnan
    send_item(make_item(CMD_STORE, 3'd7, 3'd0, 1'b0, '0, KIND_I16,
                        64'h8000_0000_0000_0001, 16'h4000));
    send_item(make_item(CMD_OVF, 3'd0, 3'd0, 1'b0, '0, KIND_I16, '0, '0));
  endtask

  // undefined command codes must leave the state alone
  task automatic test_undefined_commands();
    for (int c = 5; c <= 7; c++) begin
      send_item(make_item(c[2:0], 3'd7, 3'd7, 1'b1, 32'hFFFF_FFFF, 3'd7,
                          64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF));
    end
  endtask

  // random instruction mix: stores and frees keep the stack cycling between
  // full and empty so that both fault kinds and their absence keep coming up
  task automatic test_random_traffic(input int unsigned count);
    in_item_t    it;
    int unsigned sel;
    int unsigned vclass;
    logic [14:0] ex;
    logic [63:0] fr;
    for (int unsigned i = 0; i < count; i++) begin
      sel = $urandom_range(99);
      if (sel < 30)      it.command = CMD_STORE;
      else if (sel < 50) it.command = CMD_EMPTY;
      else if (sel < 65) it.command = CMD_OVF;
      else if (sel < 80) it.command = CMD_UNF_REG;
      else if (sel < 95) it.command = CMD_UNF_MEM;
      else               it.command = 3'($urandom_range(7, 5));
      it.st_source = 3'($urandom_range(7));
      it.st_dest   = 3'($urandom_range(7));
      it.pop_after = 1'($urandom_range(1));
      it.mem_addr  = $urandom;
      it.mem_kind  = ($urandom_range(99) < 90) ? 3'($urandom_range(KIND_F80))
                                                : 3'($urandom_range(7, 6));
      // value class: zero, denormal, max exponent, unnormal, normal
      vclass = $urandom_range(5);
      fr     = {$urandom, $urandom};
      ex     = 15'($urandom_range(32'h7FFF));
      case (vclass)
        0: begin
          fr = '0;
          ex = '0;
        end
        1: ex = '0;
        2: ex = EXP_MAX;
        3: fr[63] = 1'b0;
        default: fr[63] = 1'b1;
      endcase
      it.value_fraction      = fr;
      it.value_sign_exp[14:0] = ex;
      it.value_sign_exp[15]   = 1'($urandom_range(1));
      send_item(it);
    end
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [15:0] word;
    // every input known from time zero
    cfg_we                <= 1'b0;
    cfg_data              <= '0;
    in_ch.valid           <= 1'b0;
    in_ch.command         <= CMD_STORE;
    in_ch.st_source       <= '0;
    in_ch.st_dest         <= '0;
    in_ch.pop_after       <= 1'b0;
    in_ch.mem_addr        <= '0;
    in_ch.mem_kind        <= KIND_I16;
    in_ch.value_fraction  <= '0;
    in_ch.value_sign_exp  <= '0;

    // predictor reset state: all tags zero, top 0, status clear
    for (int r = 0; r < 8; r++) begin
      st_frac[r] = '0;
      st_sexp[r] = '0;
      st_tags[r] = TAG_ZERO;
    end
    top_ptr     = '0;
    status_bits = '0;
    ctrl_word   = CW_RESET;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    test_store_classification();
    test_unmasked_faults();
    test_masked_faults();
    test_undefined_commands();

    // four handshake patterns, each under a masked, an unmasked and a random
    // control word
    for (int m = 0; m < 4; m++) begin
      case (m)
        0: begin
          send_idle_pct = 0;
          stall_pct     = 0;
        end
        1: begin
          send_idle_pct = 70;
          stall_pct     = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct     = 70;
        end
        default: begin
          send_idle_pct = 19;
          stall_pct     = 19;
        end
      endcase
      for (int c = 0; c < 3; c++) begin
        word = 16'($urandom);
        if (c == 0) word[SW_IE_BIT] = 1'b1;
        if (c == 1) word[SW_IE_BIT] = 1'b0;
        set_control_word(word);
        test_random_traffic(92);
      end
    end

    drain_results();
    if (error_count == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule
